// ===== rtl/gn3t_pkg.sv =====
package gn3t_pkg;

	typedef logic [4:0] state_t;

	localparam logic [2:0] FN_LOAD_X = 3'd0;
	localparam logic [2:0] FN_LOAD_Y = 3'd1;
	localparam logic [2:0] FN_LOAD_Z = 3'd2;
	localparam logic [2:0] FN_LOAD_G = 3'd3;
	localparam logic [2:0] FN_QUERY  = 3'd4;

	localparam logic REG_OCTAVES = 1'b0;
	localparam logic REG_TURB    = 1'b1;

	localparam logic [3:0] OCTAVES_RST = 4'd7;

	localparam logic signed [19:0] NV_MAX = 20'sh7FFFF;
	localparam logic signed [19:0] NV_MIN = 20'sh80000;

	localparam state_t ST_IDLE = 5'd0;
	localparam state_t ST_SQ   = 5'd1;
	localparam state_t ST_ST   = 5'd2;
	localparam state_t ST_SS   = 5'd3;
	localparam state_t ST_RD   = 5'd4;
	localparam state_t ST_GR   = 5'd5;
	localparam state_t ST_D0   = 5'd6;
	localparam state_t ST_D1   = 5'd7;
	localparam state_t ST_D2   = 5'd8;
	localparam state_t ST_D3   = 5'd9;
	localparam state_t ST_W0   = 5'd10;
	localparam state_t ST_W1   = 5'd11;
	localparam state_t ST_W2   = 5'd12;
	localparam state_t ST_AC   = 5'd13;
	localparam state_t ST_OE   = 5'd14;
	localparam state_t ST_FIN  = 5'd15;

endpackage

// ===== rtl/gradient_noise_3d_turbulence.sv =====
// load word: written into its table when accepted, no result word
// query word: one result word per query (single noise counts as one octave)
// each octave: smoothstep per axis, then read, dot and weight each of 8 corners, then sum
// one shared signed multiplier does all products; one query in flight, ready low while busy
// reset clears the sequencer, result valid, octave count to 7 and turbulence mode to 0
// tables are not cleared by reset; every entry must be loaded before a query reads it
module gradient_noise_3d_turbulence #(
	parameter int TABLE_ENTRIES = 256,
	parameter int FRACTION_BITS = 16,
	parameter int MAX_OCTAVES   = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [3:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         func,
	input  logic [7:0]         entry_index,
	input  logic [7:0]         perm_value,
	input  logic signed [15:0] grad_x,
	input  logic signed [15:0] grad_y,
	input  logic signed [15:0] grad_z,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [19:0] noise_value
);
	import gn3t_pkg::*;

	localparam int FB   = FRACTION_BITS;
	localparam int IW   = $clog2(TABLE_ENTRIES);
	localparam int EW   = (IW > 8) ? IW : 8;
	localparam int PW   = FB + IW;
	localparam int MW   = (FB + 3 > 16) ? FB + 3 : 16;
	localparam int DW   = FB + 18;
	localparam int AW   = FB + 8;
	localparam int QW   = AW + 16;
	localparam int OW   = $clog2(MAX_OCTAVES + 1);
	localparam int SH_R = (FB >= 16) ? FB - 16 : 0;
	localparam int SH_L = (FB < 16) ? 16 - FB : 0;

	state_t state_q;
	logic [3:0] oct_cnt_q;
	logic turb_q;

	logic [IW-1:0] xperm [TABLE_ENTRIES];
	logic [IW-1:0] yperm [TABLE_ENTRIES];
	logic [IW-1:0] zperm [TABLE_ENTRIES];
	logic [47:0]   gmem  [TABLE_ENTRIES];

	logic [PW-1:0] pt_q [3];
	logic [FB:0]   s_q [3];
	logic [1:0]    ax_q;
	logic [2:0]    corner_q;
	logic [OW-1:0] oct_q;
	logic [OW-1:0] nocts_q;
	logic [IW-1:0] xr_q, yr_q, zr_q;
	logic [47:0]   gr_q;
	logic signed [2*MW-1:0] prod_q;
	logic signed [DW-1:0]   dot_q;
	logic signed [AW-1:0]   acc_q;
	logic signed [AW-1:0]   sum_q;
	logic                   out_valid_q;
	logic signed [19:0]     noise_q;

	logic                accept;
	logic [EW-1:0]       ent_ext;
	logic [EW-1:0]       pv_ext;
	logic [IW-1:0]       waddr;
	logic [IW-1:0]       wdata;
	logic [OW-1:0]       nocts_w;
	logic [FB-1:0]       frac [3];
	logic [IW-1:0]       cidx [3];
	logic [FB-1:0]       frac_ax;
	logic signed [MW-1:0] mult_a, mult_b;
	logic signed [MW-1:0] prod_fb;
	logic signed [MW-1:0] t_w;
	logic signed [FB:0]  ofs [3];
	logic [FB:0]         wgt [3];
	logic signed [AW-1:0] res_w;
	logic signed [QW-1:0] qv;
	logic [63:0]         px64, py64, pz64;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign ent_ext  = EW'(entry_index);
	assign pv_ext   = EW'(perm_value);
	assign waddr    = ent_ext[IW-1:0];
	assign wdata    = pv_ext[IW-1:0];
	assign px64     = 64'(point_x);
	assign py64     = 64'(point_y);
	assign pz64     = 64'(point_z);

	always_comb begin
		if (!turb_q) begin
			nocts_w = OW'(1);
		end else if (32'(oct_cnt_q) > MAX_OCTAVES) begin
			nocts_w = OW'(MAX_OCTAVES);
		end else begin
			nocts_w = OW'(oct_cnt_q);
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			frac[a] = pt_q[a][FB-1:0];
			cidx[a] = pt_q[a][PW-1:FB];
			ofs[a]  = {corner_q[2-a], frac[a]};
			wgt[a]  = corner_q[2-a] ? s_q[a] : ((FB+1)'(1) << FB) - s_q[a];
		end
	end

	assign frac_ax = frac[ax_q];
	assign prod_fb = MW'(prod_q >>> FB);
	assign t_w     = (MW'(3) << FB) - MW'({frac_ax, 1'b0});

	always_comb begin
		mult_a = '0;
		mult_b = '0;
		case (state_q)
			ST_SQ: begin
				mult_a = MW'(frac_ax);
				mult_b = MW'(frac_ax);
			end
			ST_ST: begin
				mult_a = prod_fb;
				mult_b = t_w;
			end
			ST_D0: begin
				mult_a = MW'($signed(gr_q[47:32]));
				mult_b = MW'(ofs[0]);
			end
			ST_D1: begin
				mult_a = MW'($signed(gr_q[31:16]));
				mult_b = MW'(ofs[1]);
			end
			ST_D2: begin
				mult_a = MW'($signed(gr_q[15:0]));
				mult_b = MW'(ofs[2]);
			end
			ST_W0: begin
				mult_a = MW'(dot_q >>> 15);
				mult_b = MW'(wgt[0]);
			end
			ST_W1: begin
				mult_a = prod_fb;
				mult_b = MW'(wgt[1]);
			end
			ST_W2: begin
				mult_a = prod_fb;
				mult_b = MW'(wgt[2]);
			end
			default: begin
				mult_a = '0;
				mult_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mult_a * mult_b;
	end

	always_ff @(posedge clk) begin
		if (accept && func == FN_LOAD_X) begin
			xperm[waddr] <= wdata;
		end
		xr_q <= xperm[cidx[0] + IW'(corner_q[2])];
	end

	always_ff @(posedge clk) begin
		if (accept && func == FN_LOAD_Y) begin
			yperm[waddr] <= wdata;
		end
		yr_q <= yperm[cidx[1] + IW'(corner_q[1])];
	end

	always_ff @(posedge clk) begin
		if (accept && func == FN_LOAD_Z) begin
			zperm[waddr] <= wdata;
		end
		zr_q <= zperm[cidx[2] + IW'(corner_q[0])];
	end

	always_ff @(posedge clk) begin
		if (accept && func == FN_LOAD_G) begin
			gmem[waddr] <= {grad_x, grad_y, grad_z};
		end
		gr_q <= gmem[xr_q ^ yr_q ^ zr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oct_cnt_q <= OCTAVES_RST;
			turb_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OCTAVES: oct_cnt_q <= cfg_data;
				REG_TURB:    turb_q    <= cfg_data[0];
				default:     turb_q    <= turb_q;
			endcase
		end
	end

	always_comb begin
		res_w = (turb_q && sum_q < 0) ? -sum_q : sum_q;
		qv    = (QW'(res_w) <<< SH_L) >>> SH_R;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				pt_q[0] <= px64[PW-1:0];
				pt_q[1] <= py64[PW-1:0];
				pt_q[2] <= pz64[PW-1:0];
				nocts_q <= nocts_w;
				sum_q   <= '0;
				acc_q   <= '0;
			end
			ST_SS: s_q[ax_q] <= prod_fb[FB:0];
			ST_D1: dot_q <= DW'(prod_q);
			ST_D2: dot_q <= dot_q + DW'(prod_q);
			ST_D3: dot_q <= dot_q + DW'(prod_q);
			ST_AC: acc_q <= acc_q + AW'(prod_fb);
			ST_OE: begin
				sum_q <= sum_q + (acc_q >>> oct_q);
				acc_q <= '0;
				for (int a = 0; a < 3; a++) begin
					pt_q[a] <= pt_q[a] << 1;
				end
			end
			default: begin
				dot_q <= dot_q;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ax_q        <= '0;
			corner_q    <= '0;
			oct_q       <= '0;
			out_valid_q <= 1'b0;
			noise_q     <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					ax_q     <= '0;
					corner_q <= '0;
					oct_q    <= '0;
					if (accept && func == FN_QUERY) begin
						state_q <= (nocts_w == '0) ? ST_FIN : ST_SQ;
					end
				end
				ST_SQ: state_q <= ST_ST;
				ST_ST: state_q <= ST_SS;
				ST_SS: begin
					if (ax_q == 2'd2) begin
						ax_q    <= '0;
						state_q <= ST_RD;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= ST_SQ;
					end
				end
				ST_RD: state_q <= ST_GR;
				ST_GR: state_q <= ST_D0;
				ST_D0: state_q <= ST_D1;
				ST_D1: state_q <= ST_D2;
				ST_D2: state_q <= ST_D3;
				ST_D3: state_q <= ST_W0;
				ST_W0: state_q <= ST_W1;
				ST_W1: state_q <= ST_W2;
				ST_W2: state_q <= ST_AC;
				ST_AC: begin
					corner_q <= corner_q + 3'd1;
					state_q  <= (corner_q == 3'd7) ? ST_OE : ST_RD;
				end
				ST_OE: begin
					oct_q   <= oct_q + OW'(1);
					state_q <= (oct_q + OW'(1) == nocts_q) ? ST_FIN : ST_SQ;
				end
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						if (qv > QW'(NV_MAX)) begin
							noise_q <= NV_MAX;
						end else if (qv < QW'(NV_MIN)) begin
							noise_q <= NV_MIN;
						end else begin
							noise_q <= qv[19:0];
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign noise_value = noise_q;

`ifndef SYNTHESIS
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && func == FN_QUERY |=> !in_ready)
		else $error("query accepted but block still ready");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_FIN)
		else $error("result word raised outside the finish step");

	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SQ || state_q == ST_ST || state_q == ST_SS |-> ax_q != 2'd3)
		else $error("smoothstep axis out of range");

	a_corner_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_AC && corner_q == 3'd7 |=> state_q == ST_OE && corner_q == 3'd0)
		else $error("corner loop did not close the octave");
`endif

endmodule
